/* rtl/afsm_pkg.sv */
// Shared types and constants for the animation frame slot manager.
// Used by afsm_ctrl, afsm_datapath and animation_frame_slot_manager_core; no dependencies.
package afsm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_COUNT    = 2'd0;
  localparam logic [1:0] REG_REPEAT_COUNT   = 2'd1;
  localparam logic [1:0] REG_REPEAT_FOREVER = 2'd2;

  // Decode buffer code meaning no decode this step
  localparam logic [1:0] NO_DECODE = 2'd3;

  // Largest frame count; also the marker for a buffer that holds no frame
  localparam int MAX_FRAMES = 1024;

  // Field widths
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 10;
  localparam int DUR_W   = 31;
  localparam int COUNT_W = 11;
  localparam int LOOP_W  = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the accepted input item
    logic step;  // apply the item to the slot state and load the result register
  } cmd_t;

endpackage

/* rtl/afsm_ctrl.sv */
// Controller for the animation frame slot manager: sequences capture, update and transfer.
// Depends on afsm_pkg.
module afsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output afsm_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Take an item only when nothing is in flight
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_SEND);
  assign cmd.load  = in_valid && (state == ST_IDLE);
  assign cmd.step  = (state == ST_EXEC);

  // Advance through capture, update, and result transfer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/afsm_datapath.sv */
// Datapath for the animation frame slot manager: config, slot state, frame step, result register.
// Depends on afsm_pkg; driven by commands from afsm_ctrl.
module afsm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  afsm_pkg::cmd_t                cmd,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [afsm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          opcode,
  input  logic                          info_valid,
  input  logic                          fully_received,
  input  logic                          has_required,
  input  logic [afsm_pkg::IDX_W-1:0]    required_frame,
  input  logic                          restore_previous,
  input  logic [afsm_pkg::DUR_W-1:0]    duration,
  output logic                          finished,
  output logic [afsm_pkg::DUR_W-1:0]    show_time,
  output logic [afsm_pkg::IDX_W-1:0]    frame_index,
  output logic [1:0]                    display_buffer,
  output logic [1:0]                    decode_buffer,
  output logic                          has_prior,
  output logic [afsm_pkg::IDX_W-1:0]    prior_frame,
  output logic                          copy_valid,
  output logic [1:0]                    copy_src,
  output logic [1:0]                    copy_dst
);

  // Slot frame width holds every index plus the none marker
  localparam int FW = $clog2(afsm_pkg::MAX_FRAMES + 1);
  localparam int CW = (FW > afsm_pkg::COUNT_W) ? FW : afsm_pkg::COUNT_W;
  localparam logic [CW-1:0] NONE = CW'(afsm_pkg::MAX_FRAMES);
  localparam int LW = afsm_pkg::LOOP_W;
  localparam int DW = afsm_pkg::DUR_W;
  localparam int XW = afsm_pkg::IDX_W;

  // Configuration
  logic [afsm_pkg::COUNT_W-1:0] frame_count;
  logic [LW-1:0]                repeat_count;
  logic                         repeat_forever;

  // Captured input item
  logic          op_q;
  logic          iv_q;
  logic          fr_q;
  logic          hr_q;
  logic [XW-1:0] req_q;
  logic          rp_q;
  logic [DW-1:0] dur_q;

  // Slot state
  logic [FW-1:0] slot_frame [0:2];
  logic          slot_restore_prev [0:2];
  logic [1:0]    display_slot;
  logic [1:0]    decoding_slot;
  logic [1:0]    restore_slot;
  logic          ended;
  logic [LW-1:0] loops_done;
  logic [DW-1:0] current_duration;

  // Next state
  logic [FW-1:0] slot_frame_next [0:2];
  logic          slot_restore_prev_next [0:2];
  logic [1:0]    display_slot_next;
  logic [1:0]    decoding_slot_next;
  logic [1:0]    restore_slot_next;
  logic          ended_next;
  logic [LW-1:0] loops_done_next;
  logic [DW-1:0] current_duration_next;

  // Result values
  logic          fin_r;
  logic [DW-1:0] show_r;
  logic [XW-1:0] fidx_r;
  logic [1:0]    disp_r;
  logic [1:0]    dec_r;
  logic          hp_r;
  logic [XW-1:0] pf_r;
  logic          cv_r;
  logic [1:0]    cs_r;
  logic [1:0]    cd_r;

  // A slot can serve as prior frame when it holds a plain frame within [req, next)
  function automatic logic usable(input logic [CW-1:0] f, input logic r,
                                  input logic [CW-1:0] req, input logic [CW-1:0] nxt);
    usable = (f < NONE) && !r && (f >= req) && (f < nxt);
  endfunction

  // Work out one frame step
  always_comb begin
    logic [CW-1:0] sf [0:2];
    logic          sr [0:2];
    logic [1:0]    ds;
    logic [1:0]    ks;
    logic [1:0]    rs;
    logic [1:0]    dec;
    logic [1:0]    rsv;
    logic [1:0]    disp;
    logic [1:0]    t;
    logic [CW-1:0] fc;
    logic [CW-1:0] nxt;
    logic [CW-1:0] req;
    logic [LW:0]   nl;
    logic          hr;
    logic          rp;
    logic          ae;
    logic          done;
    logic [CW-1:0] pfv;

    for (int i = 0; i < 3; i++) begin
      sf[i] = CW'(slot_frame[i]);
      sr[i] = slot_restore_prev[i];
    end
    ds  = display_slot;
    ks  = decoding_slot;
    rs  = restore_slot;
    dec = ks;
    rsv = rs;
    disp = ds;
    t   = 2'd0;
    req = CW'(req_q);
    nxt = '0;
    nl  = '0;
    hr  = hr_q;
    rp  = rp_q;
    ae  = 1'b0;
    done = 1'b0;
    pfv = '0;
    ended_next            = ended;
    loops_done_next       = loops_done;
    current_duration_next = current_duration;
    fin_r = 1'b0;
    dec_r = afsm_pkg::NO_DECODE;
    hp_r  = 1'b0;
    cv_r  = 1'b0;
    cs_r  = 2'd0;
    cd_r  = 2'd0;

    // Clamp the frame count to 1..MAX_FRAMES
    if (frame_count == '0) begin
      fc = CW'(1);
    end else if (CW'(frame_count) > NONE) begin
      fc = NONE;
    end else begin
      fc = CW'(frame_count);
    end

    // Reset item: clear end and loops, drop displayed frame unless it is frame zero
    if (op_q) begin
      ended_next      = 1'b0;
      loops_done_next = '0;
      if (sf[ds] == '0) begin
        done = 1'b1;
      end else begin
        sf[ds] = NONE;
      end
    end

    // Already ended: report finished, change nothing
    if (!done && ended_next) begin
      fin_r = 1'b1;
      done  = 1'b1;
    end

    // Next index, wrap and loop count
    if (!done) begin
      nxt = (sf[ds] >= NONE) ? '0 : sf[ds] + CW'(1);
      if (nxt == fc - CW'(1)) begin
        nl = {1'b0, loops_done_next} + (LW + 1)'(1);
        if (!repeat_forever && (nl > {1'b0, repeat_count})) ae = 1'b1;
        loops_done_next = nl[LW] ? {LW{1'b1}} : nl[LW-1:0];
      end else if (nxt >= fc) begin
        nxt = '0;
      end
      if (iv_q) begin
        if (!fr_q) begin
          ended_next = 1'b1;
          current_duration_next = '0;
          fin_r = 1'b1;
          done  = 1'b1;
        end else begin
          current_duration_next = dur_q;
        end
      end else begin
        ae = 1'b1;
        if (nxt != '0) begin
          ended_next = 1'b1;
          current_duration_next = '0;
          fin_r = 1'b1;
          done  = 1'b1;
        end else begin
          hr = 1'b0;
          rp = 1'b0;
          current_duration_next = '0;
        end
      end
    end

    if (!done) begin
      if (nxt == sf[ds] || nxt == sf[rs] || nxt == sf[ks]) begin
        // Frame already held: swap roles if needed, no decode
        if (nxt != sf[ds]) begin
          if (nxt == sf[rs]) begin
            t = ds; ds = rs; rs = t;
          end else begin
            t = ds; ds = ks; ks = t;
          end
        end
      end else begin
        // Choose the prior frame and the decode buffer
        dec = ks; rsv = rs; disp = ds;
        if (!hr) begin
          if (rp && sf[dec] < NONE && !sr[dec]) begin
            t = dec; dec = rsv; rsv = t;
          end
        end else if (usable(sf[dec], sr[dec], req, nxt)) begin
          if (rp) begin
            sf[rsv] = sf[dec];
            sr[rsv] = sr[dec];
            cv_r = 1'b1; cs_r = dec; cd_r = rsv;
          end
          hp_r = 1'b1; pfv = sf[dec];
        end else if (usable(sf[disp], sr[disp], req, nxt)) begin
          sf[dec] = sf[disp];
          sr[dec] = sr[disp];
          cv_r = 1'b1; cs_r = disp; cd_r = dec;
          hp_r = 1'b1; pfv = sf[dec];
        end else if (usable(sf[rsv], sr[rsv], req, nxt)) begin
          if (!rp) begin
            t = dec; dec = rsv; rsv = t;
          end else begin
            sf[dec] = sf[rsv];
            sr[dec] = sr[rsv];
            cv_r = 1'b1; cs_r = rsv; cd_r = dec;
          end
          hp_r = 1'b1; pfv = sf[dec];
        end
        sf[dec] = nxt;
        sr[dec] = rp;
        ds = dec;
        ks = disp;
        rs = rsv;
        dec_r = dec;
      end
      if (ae) begin
        ended_next = 1'b1;
        current_duration_next = '0;
      end
      fin_r = ae;
    end

    // Result fields from the updated state
    pf_r   = pfv[XW-1:0];
    disp_r = ds;
    fidx_r = (sf[ds] >= NONE) ? '0 : sf[ds][XW-1:0];
    show_r = fin_r ? '0 : current_duration_next;

    for (int i = 0; i < 3; i++) begin
      slot_frame_next[i]        = sf[i][FW-1:0];
      slot_restore_prev_next[i] = sr[i];
    end
    display_slot_next  = ds;
    decoding_slot_next = ks;
    restore_slot_next  = rs;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= afsm_pkg::COUNT_W'(1);
      repeat_count   <= '0;
      repeat_forever <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        afsm_pkg::REG_FRAME_COUNT:    frame_count    <= cfg_data[afsm_pkg::COUNT_W-1:0];
        afsm_pkg::REG_REPEAT_COUNT:   repeat_count   <= cfg_data[LW-1:0];
        afsm_pkg::REG_REPEAT_FOREVER: repeat_forever <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      iv_q  <= info_valid;
      fr_q  <= fully_received;
      hr_q  <= has_required;
      req_q <= required_frame;
      rp_q  <= restore_previous;
      dur_q <= duration;
    end
  end

  // Slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        slot_frame[i]        <= FW'(afsm_pkg::MAX_FRAMES);
        slot_restore_prev[i] <= 1'b0;
      end
      display_slot     <= 2'd0;
      decoding_slot    <= 2'd1;
      restore_slot     <= 2'd2;
      ended            <= 1'b0;
      loops_done       <= '0;
      current_duration <= '0;
    end else if (cmd.step) begin
      for (int i = 0; i < 3; i++) begin
        slot_frame[i]        <= slot_frame_next[i];
        slot_restore_prev[i] <= slot_restore_prev_next[i];
      end
      display_slot     <= display_slot_next;
      decoding_slot    <= decoding_slot_next;
      restore_slot     <= restore_slot_next;
      ended            <= ended_next;
      loops_done       <= loops_done_next;
      current_duration <= current_duration_next;
    end
  end

  // Result register, held until transferred
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      finished       <= fin_r;
      show_time      <= show_r;
      frame_index    <= fidx_r;
      display_buffer <= disp_r;
      decode_buffer  <= dec_r;
      has_prior      <= hp_r;
      prior_frame    <= pf_r;
      copy_valid     <= cv_r;
      copy_src       <= cs_r;
      copy_dst       <= cd_r;
    end
  end

endmodule

/* rtl/animation_frame_slot_manager_core.sv */
// Channel    Handshake               Payload
// input      in_valid / in_stall     opcode .. duration, one advance or reset item
// output     out_valid / out_stall   finished .. copy_dst, one result per item
// config     cfg_write               cfg_index, cfg_data (no wait, no read-back)
//
// An item passes through capture, then slot update, then the result register, which
// presents it; the next item is taken once the result has been transferred.
// A stall on the output holds the result and keeps the input stalled.
// Reset (rst, synchronous) empties all three buffers and restores the default config.
// Top level of the animation frame slot manager; depends on afsm_pkg, afsm_ctrl, afsm_datapath.
module animation_frame_slot_manager_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [afsm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic                          info_valid,
  input  logic                          fully_received,
  input  logic                          has_required,
  input  logic [afsm_pkg::IDX_W-1:0]    required_frame,
  input  logic                          restore_previous,
  input  logic [afsm_pkg::DUR_W-1:0]    duration,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          finished,
  output logic [afsm_pkg::DUR_W-1:0]    show_time,
  output logic [afsm_pkg::IDX_W-1:0]    frame_index,
  output logic [1:0]                    display_buffer,
  output logic [1:0]                    decode_buffer,
  output logic                          has_prior,
  output logic [afsm_pkg::IDX_W-1:0]    prior_frame,
  output logic                          copy_valid,
  output logic [1:0]                    copy_src,
  output logic [1:0]                    copy_dst
);

  afsm_pkg::cmd_t cmd;

  // Sequence the item through capture, update and transfer
  afsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Slot state, frame step and result register
  afsm_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .info_valid       (info_valid),
    .fully_received   (fully_received),
    .has_required     (has_required),
    .required_frame   (required_frame),
    .restore_previous (restore_previous),
    .duration         (duration),
    .finished         (finished),
    .show_time        (show_time),
    .frame_index      (frame_index),
    .display_buffer   (display_buffer),
    .decode_buffer    (decode_buffer),
    .has_prior        (has_prior),
    .prior_frame      (prior_frame),
    .copy_valid       (copy_valid),
    .copy_src         (copy_src),
    .copy_dst         (copy_dst)
  );

endmodule

/* tb/sv/frame_slot_checker.sv */
// Checker for the animation frame slot manager: mirrors the slot roles, the loop count and
// the configuration, predicts one outcome per accepted frame item and compares each result.
// Depends on afsm_pkg for register indexes, the no-decode code and field widths.
module frame_slot_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [afsm_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       opcode,
  input  logic                       info_valid,
  input  logic                       fully_received,
  input  logic                       has_required,
  input  logic [afsm_pkg::IDX_W-1:0] required_frame,
  input  logic                       restore_previous,
  input  logic [afsm_pkg::DUR_W-1:0] duration,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       finished,
  input  logic [afsm_pkg::DUR_W-1:0] show_time,
  input  logic [afsm_pkg::IDX_W-1:0] frame_index,
  input  logic [1:0]                 display_buffer,
  input  logic [1:0]                 decode_buffer,
  input  logic                       has_prior,
  input  logic [afsm_pkg::IDX_W-1:0] prior_frame,
  input  logic                       copy_valid,
  input  logic [1:0]                 copy_src,
  input  logic [1:0]                 copy_dst,
  output int                         mismatch_count,
  output int                         outcomes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import afsm_pkg::*;

  // Marker for a buffer that holds no frame
  localparam int NO_FRAME = 1024;

  typedef struct packed {
    logic             fin;
    logic [DUR_W-1:0] show;
    logic [IDX_W-1:0] fidx;
    logic [1:0]       disp_buf;
    logic [1:0]       dec_buf;
    logic             hp;
    logic [IDX_W-1:0] pf;
    logic             cv;
    logic [1:0]       cs;
    logic [1:0]       cd;
  } frame_outcome_t;

  frame_outcome_t frame_outcomes[$];
  int errors = 0;

  // Mirrored configuration
  logic [COUNT_W-1:0] cfg_frames;
  logic [LOOP_W-1:0]  cfg_repeats;
  logic               cfg_forever;

  // Mirrored slot state
  logic [COUNT_W-1:0] buf_frame[3];
  logic               buf_rp[3];
  logic [1:0]         show_slot;
  logic [1:0]         work_slot;
  logic [1:0]         keep_slot;
  logic               anim_done;
  logic [LOOP_W-1:0]  loop_cnt;
  logic [DUR_W-1:0]   cur_show;

  function automatic void reset_slots();
    cfg_frames  = 11'd1;
    cfg_repeats = '0;
    cfg_forever = 1'b0;
    for (int i = 0; i < 3; i++) begin
      buf_frame[i] = COUNT_W'(NO_FRAME);
      buf_rp[i]    = 1'b0;
    end
    show_slot = 2'd0;
    work_slot = 2'd1;
    keep_slot = 2'd2;
    anim_done = 1'b0;
    loop_cnt  = '0;
    cur_show  = '0;
  endfunction

  function automatic frame_outcome_t make_outcome(logic fin, logic [1:0] dec, logic hp,
                                                  int pf, logic cv, logic [1:0] cs,
                                                  logic [1:0] cd);
    frame_outcome_t o;
    o.fin      = fin;
    o.show     = fin ? '0 : cur_show;
    o.fidx     = (int'(buf_frame[show_slot]) >= NO_FRAME) ? '0 :
                 buf_frame[show_slot][IDX_W-1:0];
    o.disp_buf = show_slot;
    o.dec_buf  = dec;
    o.hp       = hp;
    o.pf       = IDX_W'(pf);
    o.cv       = cv;
    o.cs       = cs;
    o.cd       = cd;
    return o;
  endfunction

  // A buffer may serve as prior when it holds a composed frame in [req, nxt)
  function automatic logic prior_ok(logic [1:0] s, int req, int nxt);
    int f;
    f = int'(buf_frame[s]);
    if (f >= NO_FRAME || buf_rp[s]) return 1'b0;
    return (f >= req) && (f < nxt);
  endfunction

  function automatic void end_animation();
    anim_done = 1'b1;
    cur_show  = '0;
  endfunction

  // Advance the slot roles for one frame item and return the outcome it reports
  function automatic frame_outcome_t advance_slots(logic op, logic iv, logic fr, logic hr,
                                                   logic [IDX_W-1:0] req, logic rp,
                                                   logic [DUR_W-1:0] dur);
    int fc, cur, nxt, nl, pfv;
    logic ae, hpv, cvv;
    logic [1:0] csv, cdv, dslot, rslot, pslot, t;
    fc = int'(cfg_frames);
    if (fc == 0) fc = 1;
    if (fc > NO_FRAME) fc = NO_FRAME;
    ae = 1'b0; hpv = 1'b0; cvv = 1'b0; pfv = 0; csv = '0; cdv = '0;

    // Reset item: a displayed frame zero only clears the end flag and loop count
    if (op) begin
      anim_done = 1'b0;
      loop_cnt  = '0;
      if (buf_frame[show_slot] == 0) return make_outcome(1'b0, NO_DECODE, 0, 0, 0, 0, 0);
      buf_frame[show_slot] = COUNT_W'(NO_FRAME);
    end
    if (anim_done) return make_outcome(1'b1, NO_DECODE, 0, 0, 0, 0, 0);

    // Next index with wrap and loop count on the last frame
    cur = int'(buf_frame[show_slot]);
    nxt = (cur >= NO_FRAME) ? 0 : cur + 1;
    if (nxt == fc - 1) begin
      nl = int'(loop_cnt) + 1;
      if (!cfg_forever && nl > int'(cfg_repeats)) ae = 1'b1;
      loop_cnt = (nl > 65535) ? 16'hFFFF : LOOP_W'(nl);
    end else if (nxt >= fc) begin
      nxt = 0;
    end

    if (iv) begin
      if (!fr) begin
        end_animation();
        return make_outcome(1'b1, NO_DECODE, 0, 0, 0, 0, 0);
      end
      cur_show = dur;
    end else begin
      // Missing info: still image at frame zero, otherwise end at once
      ae = 1'b1;
      if (nxt != 0) begin
        end_animation();
        return make_outcome(1'b1, NO_DECODE, 0, 0, 0, 0, 0);
      end
      hr = 1'b0;
      rp = 1'b0;
      cur_show = '0;
    end

    // Reuse a buffer that already holds the next frame
    if (nxt == int'(buf_frame[show_slot]) || nxt == int'(buf_frame[keep_slot]) ||
        nxt == int'(buf_frame[work_slot])) begin
      if (nxt != int'(buf_frame[show_slot])) begin
        if (nxt == int'(buf_frame[keep_slot])) begin
          t = show_slot; show_slot = keep_slot; keep_slot = t;
        end else begin
          t = show_slot; show_slot = work_slot; work_slot = t;
        end
      end
      if (ae) end_animation();
      return make_outcome(ae, NO_DECODE, 0, 0, 0, 0, 0);
    end

    // Pick the decode buffer and the prior frame
    dslot = work_slot; rslot = keep_slot; pslot = show_slot;
    if (!hr) begin
      if (rp && int'(buf_frame[dslot]) < NO_FRAME && !buf_rp[dslot]) begin
        t = dslot; dslot = rslot; rslot = t;
      end
    end else if (prior_ok(dslot, int'(req), nxt)) begin
      if (rp) begin
        buf_frame[rslot] = buf_frame[dslot];
        buf_rp[rslot]    = buf_rp[dslot];
        cvv = 1'b1; csv = dslot; cdv = rslot;
      end
      hpv = 1'b1; pfv = int'(buf_frame[dslot]);
    end else if (prior_ok(pslot, int'(req), nxt)) begin
      buf_frame[dslot] = buf_frame[pslot];
      buf_rp[dslot]    = buf_rp[pslot];
      cvv = 1'b1; csv = pslot; cdv = dslot;
      hpv = 1'b1; pfv = int'(buf_frame[dslot]);
    end else if (prior_ok(rslot, int'(req), nxt)) begin
      if (!rp) begin
        t = dslot; dslot = rslot; rslot = t;
      end else begin
        buf_frame[dslot] = buf_frame[rslot];
        buf_rp[dslot]    = buf_rp[rslot];
        cvv = 1'b1; csv = rslot; cdv = dslot;
      end
      hpv = 1'b1; pfv = int'(buf_frame[dslot]);
    end

    // Rotate roles: decoded buffer becomes the display
    buf_frame[dslot] = COUNT_W'(nxt);
    buf_rp[dslot]    = rp;
    show_slot = dslot;
    work_slot = pslot;
    keep_slot = rslot;
    if (ae) end_animation();
    return make_outcome(ae, dslot, hpv, pfv, cvv, csv, cdv);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Track config writes, compare result transfers, predict on input transfers
  always @(posedge clk) begin
    frame_outcome_t want;
    if (rst) begin
      reset_slots();
      frame_outcomes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_COUNT:    cfg_frames  = cfg_data[COUNT_W-1:0];
          REG_REPEAT_COUNT:   cfg_repeats = cfg_data[LOOP_W-1:0];
          REG_REPEAT_FOREVER: cfg_forever = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_outcomes.size() == 0) begin
          $display("%0t: result transfer with no frame item pending", $time);
          errors++;
        end else begin
          want = frame_outcomes.pop_front();
          check_field("finished", 32'(want.fin), 32'(finished));
          check_field("show_time", 32'(want.show), 32'(show_time));
          check_field("frame_index", 32'(want.fidx), 32'(frame_index));
          check_field("display_buffer", 32'(want.disp_buf), 32'(display_buffer));
          check_field("decode_buffer", 32'(want.dec_buf), 32'(decode_buffer));
          check_field("has_prior", 32'(want.hp), 32'(has_prior));
          check_field("prior_frame", 32'(want.pf), 32'(prior_frame));
          check_field("copy_valid", 32'(want.cv), 32'(copy_valid));
          check_field("copy_src", 32'(want.cs), 32'(copy_src));
          check_field("copy_dst", 32'(want.cd), 32'(copy_dst));
        end
      end
      if (in_valid && !in_stall) begin
        frame_outcomes.push_back(advance_slots(opcode, info_valid, fully_received,
                                               has_required, required_frame,
                                               restore_previous, duration));
      end
    end
    mismatch_count <= errors;
    outcomes_due   <= frame_outcomes.size();
  end

endmodule

/* tb/sv/tb.sv */
// Top of the frame slot manager testbench: clock, reset, configuration phases, frame items
// with random gaps and result stalls, and the final verdict.
// Depends on afsm_pkg, animation_frame_slot_manager_core and frame_slot_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afsm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;

  logic                clk;
  logic                rst              = 1'b1;
  logic                cfg_write        = 1'b0;
  logic [1:0]          cfg_index        = REG_FRAME_COUNT;
  logic [CFG_W-1:0]    cfg_data         = '0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic                opcode           = 1'b0;
  logic                info_valid       = 1'b0;
  logic                fully_received   = 1'b0;
  logic                has_required     = 1'b0;
  logic [IDX_W-1:0]    required_frame   = '0;
  logic                restore_previous = 1'b0;
  logic [DUR_W-1:0]    duration         = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic                finished;
  logic [DUR_W-1:0]    show_time;
  logic [IDX_W-1:0]    frame_index;
  logic [1:0]          display_buffer;
  logic [1:0]          decode_buffer;
  logic                has_prior;
  logic [IDX_W-1:0]    prior_frame;
  logic                copy_valid;
  logic [1:0]          copy_src;
  logic [1:0]          copy_dst;

  int mismatches;
  int outcomes_due;
  int cur_fc  = 1;
  bit idle_on = 1'b1;

  animation_frame_slot_manager_core i_dut (.*);

  frame_slot_checker i_checker (
    .mismatch_count (mismatches),
    .outcomes_due   (outcomes_due),
    .*
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short sender gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive one frame item and hold it until its transfer
  task automatic send_frame(input logic op, input logic iv, input logic fr, input logic hr,
                            input logic [IDX_W-1:0] req, input logic rp,
                            input logic [DUR_W-1:0] dur);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode           <= op;
    info_valid       <= iv;
    fully_received   <= fr;
    has_required     <= hr;
    required_frame   <= req;
    restore_previous <= rp;
    duration         <= dur;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every pending result has been transferred
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcomes_due != 0) @(posedge clk);
  endtask

  task automatic write_settings(input int fc, input int rc, input int rf);
    wait_results_done();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_COUNT;
    cfg_data  <= CFG_W'(fc);
    @(posedge clk);
    cfg_index <= REG_REPEAT_COUNT;
    cfg_data  <= CFG_W'(rc);
    @(posedge clk);
    cfg_index <= REG_REPEAT_FOREVER;
    cfg_data  <= CFG_W'(rf);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_fc = fc;
  endtask

  // Random item biased toward well-formed advances with occasional resets and breaks
  task automatic send_random_frame();
    int r;
    logic [IDX_W-1:0] req;
    logic [DUR_W-1:0] dur;
    r = $urandom_range(0, 99);
    if (r < 40) req = '0;
    else if (r < 85) req = IDX_W'($urandom_range(0, cur_fc - 1));
    else req = IDX_W'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < 5) dur = '0;
    else if (r < 10) dur = '1;
    else dur = DUR_W'($urandom());
    send_frame($urandom_range(0, 99) < 7, $urandom_range(0, 99) < 93,
               $urandom_range(0, 99) < 95, 1'($urandom_range(0, 1)), req,
               $urandom_range(0, 99) < 35, dur);
  endtask

  // Result side: stretches free of stall, mostly short stalls, a few long ones
  initial begin : result_stall
    int r;
    int len;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 30);
      end else begin
        out_stall <= 1'b1;
        len = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int fc, rc, rf;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default config, single frame: still image, ended, reset at frame zero, incomplete data
    send_frame(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 31'd0);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd1023, 1'b1, 31'h7FFFFFFF);
    send_frame(1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 31'd5);
    send_frame(1'b0, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 31'd7);
    send_frame(1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 31'd9);

    // Four frames, one repeat: priors, restore disposal, wrap, end on last loop
    write_settings(4, 1, 0);
    send_frame(1'b0, 1'b1, 1'b1, 1'b0, 10'd0, 1'b1, 31'h7FFFFFFF);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 1'b0, 31'd100);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd1, 1'b1, 31'd200);
    send_frame(1'b0, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 31'd300);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd1023, 1'b0, 31'd1);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 31'd2);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd2, 1'b0, 31'd3);
    send_frame(1'b0, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 31'd4);
    send_frame(1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 31'd5);
    send_frame(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 31'd0);
    send_frame(1'b1, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, 31'd0);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 31'd6);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 31'd7);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd1, 1'b0, 31'd8);
    send_frame(1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 31'd9);

    // Random phases, extremes of the settings first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fc = 1024; rc = 65535; rf = 0; end
        1: begin fc = 1;    rc = 0;     rf = 1; end
        2: begin fc = 2;    rc = 0;     rf = 0; end
        3: begin fc = 1;    rc = 65535; rf = 0; end
        4: begin fc = 1024; rc = 0;     rf = 1; end
        default: begin
          fc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 12);
          rc = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 3);
          rf = int'($urandom_range(0, 3) == 0);
        end
      endcase
      write_settings(fc, rc, rf);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 3) wait_results_done();
        send_random_frame();
      end
    end

    wait_results_done();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/afsm_pkg.sv
rtl/afsm_ctrl.sv
rtl/afsm_datapath.sv
rtl/animation_frame_slot_manager_core.sv
tb/sv/frame_slot_checker.sv
tb/sv/tb.sv
